FILE: rtl/core/sphx_pkg.sv
// Shared types, constants and functions of the sample packer and hex encoder.
package sphx_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CHAR_W  = 7;
   localparam int unsigned CODE_W  = 2;
   localparam int unsigned FILL_W  = 3;

   localparam logic [CODE_W-1:0] CODE_BITS_1 = 2'd0;
   localparam logic [CODE_W-1:0] CODE_BITS_2 = 2'd1;
   localparam logic [CODE_W-1:0] CODE_BITS_4 = 2'd2;
   localparam logic [CODE_W-1:0] CODE_BITS_8 = 2'd3;
   localparam logic [CODE_W-1:0] CODE_RESET  = CODE_BITS_8;

   localparam logic [0:0] FUNC_SAMPLE = 1'b0;
   localparam logic [0:0] FUNC_FINISH = 1'b1;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'd87;   // 'a' minus ten

   // Work item handed from the packer to the encoder
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              has_byte;
      logic              done;
   } cmd_type;

   function automatic logic [BYTE_W-1:0] sample_mask(input logic [CODE_W-1:0] code);
      logic [BYTE_W-1:0] m;
      case (code)
         CODE_BITS_1: m = 8'h01;
         CODE_BITS_2: m = 8'h03;
         CODE_BITS_4: m = 8'h0F;
         default:     m = 8'hFF;
      endcase
      return m;
   endfunction

   function automatic logic [FILL_W-1:0] sample_step(input logic [CODE_W-1:0] code);
      logic [FILL_W-1:0] s;
      case (code)
         CODE_BITS_1: s = 3'd1;
         CODE_BITS_2: s = 3'd2;
         CODE_BITS_4: s = 3'd4;
         default:     s = 3'd0;
      endcase
      return s;
   endfunction

   // Bit position of the first sample in a fresh byte
   function automatic logic [FILL_W-1:0] fill_start(input logic [CODE_W-1:0] code);
      logic [FILL_W-1:0] f;
      case (code)
         CODE_BITS_1: f = 3'd7;
         CODE_BITS_2: f = 3'd6;
         CODE_BITS_4: f = 3'd4;
         default:     f = 3'd0;
      endcase
      return f;
   endfunction

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + CHAR_W'(nib);
      end else begin
         c = CHAR_ALPHA + CHAR_W'(nib);
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/sphx_req_if.sv
// Request channel: valid/ready handshake with function and sample payload.
interface sphx_req_if;
   logic       valid;
   logic       ready;
   logic [0:0] func;
   logic [7:0] sample;

   modport source (output valid, output func, output sample, input ready);
   modport sink   (input valid, input func, input sample, output ready);
endinterface

FILE: rtl/core/sphx_rsp_if.sv
// Response channel: valid/ready handshake with packed byte and hex characters.
interface sphx_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] packed_byte;
   logic [6:0] hex_high;
   logic [6:0] hex_low;
   logic       line_break;
   logic       byte_valid;
   logic       done_res;

   modport source (output valid, output packed_byte, output hex_high, output hex_low,
                   output line_break, output byte_valid, output done_res, input ready);
   modport sink   (input valid, input packed_byte, input hex_high, input hex_low,
                   input line_break, input byte_valid, input done_res, output ready);
endinterface

FILE: rtl/core/sphx_front.sv
// Packer front end: takes requests, packs samples and tracks padding alignment.
module sphx_front #(
   parameter int unsigned PAD_BYTES = 384
) (
   input  logic                        clock,
   input  logic                        reset,
   sphx_req_if.sink                    req_chan,
   input  logic                        csr_wr_en,
   input  logic [sphx_pkg::CODE_W-1:0] csr_wr_data,
   input  logic                        q_full,
   output logic                        push,
   output sphx_pkg::cmd_type           push_cmd
);

   localparam int unsigned TOT_W = (PAD_BYTES > 1) ? $clog2(PAD_BYTES) : 1;
   localparam logic [TOT_W-1:0] TOT_LAST = TOT_W'(PAD_BYTES - 1);

   logic [sphx_pkg::CODE_W-1:0] code_ff, code_in;
   logic [sphx_pkg::BYTE_W-1:0] acc_ff, acc_in;
   logic [sphx_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic                        pend_ff, pend_in;
   logic [TOT_W-1:0]            total_ff, total_in;

   logic                        accept;
   logic [sphx_pkg::BYTE_W-1:0] acc_or;
   logic [TOT_W-1:0]            total_inc;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;
   assign acc_or    = acc_ff | ((req_chan.sample & sphx_pkg::sample_mask(code_ff)) << fill_ff);
   assign total_inc = (total_ff == TOT_LAST) ? '0 : total_ff + 1'b1;

   always_comb begin
      code_in  = code_ff;
      acc_in   = acc_ff;
      fill_in  = fill_ff;
      pend_in  = pend_ff;
      total_in = total_ff;
      push     = 1'b0;
      push_cmd = '0;
      if (csr_wr_en) begin
         // new width restarts packing, counters kept
         code_in = csr_wr_data;
         acc_in  = '0;
         pend_in = 1'b0;
         fill_in = sphx_pkg::fill_start(csr_wr_data);
      end else if (accept) begin
         if (req_chan.func == sphx_pkg::FUNC_SAMPLE) begin
            if (fill_ff == '0) begin
               push              = 1'b1;
               push_cmd.data     = acc_or;
               push_cmd.has_byte = 1'b1;
               total_in          = total_inc;
               acc_in            = '0;
               pend_in           = 1'b0;
               fill_in           = sphx_pkg::fill_start(code_ff);
            end else begin
               acc_in  = acc_or;
               pend_in = 1'b1;
               fill_in = fill_ff - sphx_pkg::sample_step(code_ff);
            end
         end else begin
            push = 1'b1;
            if (pend_ff) begin
               push_cmd.data     = acc_ff;
               push_cmd.has_byte = 1'b1;
               total_in          = total_inc;
               acc_in            = '0;
               pend_in           = 1'b0;
               fill_in           = sphx_pkg::fill_start(code_ff);
            end else if (total_ff != '0) begin
               // zero pad byte; done once it lands on the boundary
               push_cmd.has_byte = 1'b1;
               push_cmd.done     = (total_inc == '0);
               total_in          = total_inc;
            end else begin
               push_cmd.done = 1'b1;
               total_in      = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff  <= sphx_pkg::CODE_RESET;
         acc_ff   <= '0;
         fill_ff  <= sphx_pkg::fill_start(sphx_pkg::CODE_RESET);
         pend_ff  <= 1'b0;
         total_ff <= '0;
      end else begin
         code_ff  <= code_in;
         acc_ff   <= acc_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
         total_ff <= total_in;
      end
   end

endmodule

FILE: rtl/core/sphx_queue.sv
// Two-entry queue between the packer and the encoder.
module sphx_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sphx_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              avail,
   output sphx_pkg::cmd_type pop_cmd
);

   sphx_pkg::cmd_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full    = (cnt_ff == 2'd2);
   assign avail   = (cnt_ff != 2'd0);
   assign pop_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

FILE: rtl/core/sphx_back.sv
// Encoder back end: hex characters, line break counting and response register.
module sphx_back #(
   parameter int unsigned LINE_BYTES = 30
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              avail,
   input  sphx_pkg::cmd_type pop_cmd,
   output logic              pop,
   sphx_rsp_if.source        rsp_chan
);

   localparam int unsigned LINE_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
   localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(LINE_BYTES - 1);

   logic [LINE_W-1:0]           line_ff, line_in;
   logic                        vld_ff, vld_in;
   logic [sphx_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic [sphx_pkg::CHAR_W-1:0] hi_ff, hi_in;
   logic [sphx_pkg::CHAR_W-1:0] lo_ff, lo_in;
   logic                        brk_ff, brk_in;
   logic                        bv_ff, bv_in;
   logic                        done_ff, done_in;
   logic                        wrap;

   assign pop  = avail && (!vld_ff || rsp_chan.ready);
   assign wrap = (line_ff == LINE_LAST);

   always_comb begin
      line_in = line_ff;
      vld_in  = vld_ff && !rsp_chan.ready;
      byte_in = byte_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      brk_in  = brk_ff;
      bv_in   = bv_ff;
      done_in = done_ff;
      if (pop) begin
         vld_in  = 1'b1;
         byte_in = pop_cmd.data;
         hi_in   = sphx_pkg::hex_char(pop_cmd.data[7:4]);
         lo_in   = sphx_pkg::hex_char(pop_cmd.data[3:0]);
         bv_in   = pop_cmd.has_byte;
         done_in = pop_cmd.done;
         brk_in  = pop_cmd.has_byte && wrap;
         if (pop_cmd.has_byte) begin
            line_in = wrap ? '0 : line_ff + 1'b1;
         end
         if (pop_cmd.done) begin
            line_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= '0;
         vld_ff  <= 1'b0;
      end else begin
         line_ff <= line_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      brk_ff  <= brk_in;
      bv_ff   <= bv_in;
      done_ff <= done_in;
   end

   assign rsp_chan.valid       = vld_ff;
   assign rsp_chan.packed_byte = byte_ff;
   assign rsp_chan.hex_high    = hi_ff;
   assign rsp_chan.hex_low     = lo_ff;
   assign rsp_chan.line_break  = brk_ff;
   assign rsp_chan.byte_valid  = bv_ff;
   assign rsp_chan.done_res    = done_ff;

endmodule

FILE: rtl/core/sample_packer_hex_encoder.sv
// A request accepted by the front end is written to the queue, and from there it is popped
// into the response register once that register is free, which makes its response valid.
// Throughput: one request per cycle; the packer front end feeds a two-entry queue
// that the encoder back end drains into the response register, so either side may stall.
// Requests that only add a sample to a partly filled byte give no response.
// Reset: synchronous, active high; sample width returns to 8 bits, packing and counters clear.
module sample_packer_hex_encoder #(
   parameter int unsigned LINE_BYTES = 30,
   parameter int unsigned PAD_BYTES  = 384
) (
   input  logic                        clock,
   input  logic                        reset,
   sphx_req_if.sink                    req_chan,
   sphx_rsp_if.source                  rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [sphx_pkg::CODE_W-1:0] csr_wr_data
);

   logic              q_full;
   logic              push;
   sphx_pkg::cmd_type push_cmd;
   logic              pop;
   logic              avail;
   sphx_pkg::cmd_type pop_cmd;

   sphx_front #(
      .PAD_BYTES (PAD_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   sphx_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .avail    (avail),
      .pop_cmd  (pop_cmd)
   );

   sphx_back #(
      .LINE_BYTES (LINE_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .avail    (avail),
      .pop_cmd  (pop_cmd),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
